// ===== rtl/ctq_pkg.sv =====
// ctq_pkg: shared sizes, codes and controller/datapath structs for the
// cancellable timer queue. No dependencies.
package ctq_pkg;

  localparam int CAPACITY    = 16;
  localparam int MAX_RESULTS = 16;
  localparam int IDX_W       = $clog2(CAPACITY);
  localparam int CNT_W       = $clog2(MAX_RESULTS);
  localparam int MODE_W      = 2;
  localparam int KIND_W      = 2;
  localparam int DELAY_W     = 16;
  localparam int ID_W        = 32;
  localparam int TICK_W      = 32;

  // Highest id handed out; after it the sequence restarts at one.
  localparam logic [ID_W-1:0] ID_FIRST = ID_W'(1);
  localparam logic [ID_W-1:0] ID_LAST  = {{(ID_W-1){1'b1}}, 1'b0};

  typedef enum logic [MODE_W-1:0] {
    MODE_POST   = 2'd0,
    MODE_CANCEL = 2'd1,
    MODE_TICK   = 2'd2
  } mode_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_POST    = 2'd0,
    KIND_CANCEL  = 2'd1,
    KIND_EXPIRED = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_EMIT
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic load;       // capture input word
    logic do_post;
    logic do_cancel;
    logic snap;       // latch expired set, start scan
    logic scan_step;  // examine one entry
    logic emit;       // send best entry as expired
  } ctq_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              out_free;
    logic              scan_end;
    logic              best_found;
    logic              emit_last;
  } ctq_sts_t;

endpackage

// ===== rtl/ctq_in_if.sv =====
// ctq_in_if: input channel of the timer queue (valid/ready plus one word).
// Depends on ctq_pkg.
interface ctq_in_if import ctq_pkg::*;;
  logic               valid;
  logic               ready;
  logic [MODE_W-1:0]  mode;
  logic [DELAY_W-1:0] delay_ticks;
  logic [ID_W-1:0]    target_id;

  modport source (output valid, mode, delay_ticks, target_id, input ready);
  modport sink   (input valid, mode, delay_ticks, target_id, output ready);
endinterface

// ===== rtl/ctq_out_if.sv =====
// ctq_out_if: result channel of the timer queue (valid/ready plus one word).
// Depends on ctq_pkg.
interface ctq_out_if import ctq_pkg::*;;
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [ID_W-1:0]   timer_id;
  logic              failed;
  logic              last;

  modport source (output valid, kind, timer_id, failed, last, input ready);
  modport sink   (input valid, kind, timer_id, failed, last, output ready);
endinterface

// ===== rtl/cancellable_timer_queue_top.sv =====
// cancellable_timer_queue_top: pending-timer table with post, cancel, tick.
// Depends on ctq_pkg, ctq_in_if, ctq_out_if, ctq_ctrl, ctq_dpath.
//
//   channel | dir | payload                              | handshake
//   --------+-----+--------------------------------------+-------------
//   in_i    | in  | mode, delay_ticks, target_id         | valid/ready
//   out_o   | out | kind, timer_id, failed, last         | valid/ready
//
// Post and cancel: each word is accepted, then matched in parallel across all
//   entries; the sequencer waits in execute while the result register is held.
// Tick: after the accept, a minimum-id scan over the table, one entry per
//   cycle, picks each expired timer in turn, and that timer is then emitted.
// Reset clears valid bits, the tick count and the id counter (back to one);
//   no clearing pass. A stalled output holds the result register and the
//   sequencer; the next input word is taken as soon as the sequencer is idle.
module cancellable_timer_queue_top import ctq_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  ctq_in_if.sink    in_i,
  ctq_out_if.source out_o
);

  ctq_cmd_t cmd;
  ctq_sts_t sts;
  logic     in_ready;

  // sequencer: idle / execute / scan / emit
  ctq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // table, counters, scan unit, result register
  ctq_dpath u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .mode_i        (in_i.mode),
    .delay_ticks_i (in_i.delay_ticks),
    .target_id_i   (in_i.target_id),
    .out_valid_o   (out_o.valid),
    .out_ready_i   (out_o.ready),
    .kind_o        (out_o.kind),
    .timer_id_o    (out_o.timer_id),
    .failed_o      (out_o.failed),
    .last_o        (out_o.last)
  );

  assign in_i.ready = in_ready;

endmodule

// ===== rtl/ctq_ctrl.sv =====
// ctq_ctrl: sequencing state machine of the timer queue.
// Depends on ctq_pkg.
module ctq_ctrl import ctq_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  ctq_sts_t sts_i,
  output ctq_cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        case (sts_i.mode)
          MODE_POST, MODE_CANCEL: begin
            if (sts_i.out_free) state_d = ST_IDLE;
          end
          MODE_TICK: state_d = ST_SCAN;
          default:   state_d = ST_IDLE;
        endcase
      end
      ST_SCAN: begin
        if (sts_i.scan_end) state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (!sts_i.best_found) begin
          state_d = ST_IDLE;
        end else if (sts_i.out_free) begin
          state_d = sts_i.emit_last ? ST_IDLE : ST_SCAN;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_EXEC: begin
        cmd_o.do_post   = (sts_i.mode == MODE_POST)   && sts_i.out_free;
        cmd_o.do_cancel = (sts_i.mode == MODE_CANCEL) && sts_i.out_free;
        cmd_o.snap      = (sts_i.mode == MODE_TICK);
      end
      ST_SCAN: cmd_o.scan_step = 1'b1;
      ST_EMIT: cmd_o.emit = sts_i.best_found && sts_i.out_free;
      default: ;
    endcase
  end

endmodule

// ===== rtl/ctq_dpath.sv =====
// ctq_dpath: timer table, id/tick counters, scan unit and result register.
// Depends on ctq_pkg.
module ctq_dpath import ctq_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ctq_cmd_t           cmd_i,
  output ctq_sts_t           sts_o,
  input  logic [MODE_W-1:0]  mode_i,
  input  logic [DELAY_W-1:0] delay_ticks_i,
  input  logic [ID_W-1:0]    target_id_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [KIND_W-1:0]  kind_o,
  output logic [ID_W-1:0]    timer_id_o,
  output logic               failed_o,
  output logic               last_o
);

  // captured input word
  logic [MODE_W-1:0]  mode_q;
  logic [DELAY_W-1:0] delay_q;
  logic [ID_W-1:0]    target_q;

  // timer table
  logic [CAPACITY-1:0] valid_q;
  logic [ID_W-1:0]     id_q [CAPACITY];
  logic [TICK_W-1:0]   dl_q [CAPACITY];

  logic [ID_W-1:0]   next_id_q;
  logic [TICK_W-1:0] now_q;

  // tick scan state
  logic [CAPACITY-1:0] pend_q;
  logic [IDX_W-1:0]    idx_q;
  logic                best_found_q;
  logic [IDX_W-1:0]    best_idx_q;
  logic [ID_W-1:0]     best_id_q;
  logic [CNT_W-1:0]    cnt_q;

  // result register
  logic              out_valid_q;
  logic [KIND_W-1:0] kind_q;
  logic [ID_W-1:0]   timer_id_q;
  logic              failed_q;
  logic              last_q;

  // parallel match logic
  logic                free_found, hit_found;
  logic [IDX_W-1:0]    free_idx, hit_idx;
  logic [CAPACITY-1:0] expired;
  logic [TICK_W-1:0]   diff [CAPACITY];
  logic                cand;
  logic [CAPACITY-1:0] pend_left;
  logic                out_free;
  logic                out_wr;

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    hit_found  = 1'b0;
    hit_idx    = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (!free_found && !valid_q[i]) begin
        free_found = 1'b1;
        free_idx   = IDX_W'(i);
      end
      if (!hit_found && valid_q[i] && (id_q[i] == target_q)) begin
        hit_found = 1'b1;
        hit_idx   = IDX_W'(i);
      end
    end
  end

  // deadline passed when (now - deadline) is non-negative as signed
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      diff[i]    = now_q - dl_q[i];
      expired[i] = valid_q[i] && !diff[i][TICK_W-1];
    end
  end

  assign cand      = pend_q[idx_q] && (!best_found_q || (id_q[idx_q] < best_id_q));
  assign pend_left = pend_q & ~(CAPACITY'(1) << best_idx_q);
  assign out_free  = !out_valid_q || out_ready_i;
  assign out_wr    = cmd_i.do_post || cmd_i.do_cancel || cmd_i.emit;

  assign sts_o.mode       = mode_q;
  assign sts_o.out_free   = out_free;
  assign sts_o.scan_end   = (idx_q == IDX_W'(CAPACITY - 1));
  assign sts_o.best_found = best_found_q;
  assign sts_o.emit_last  = (pend_left == '0) || (cnt_q == CNT_W'(MAX_RESULTS - 1));

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q      <= '0;
      next_id_q    <= ID_FIRST;
      now_q        <= '0;
      pend_q       <= '0;
      idx_q        <= '0;
      best_found_q <= 1'b0;
      cnt_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cmd_i.load && (mode_i == MODE_TICK)) begin
        now_q <= now_q + TICK_W'(1);
      end
      if (cmd_i.do_post && free_found) begin
        valid_q[free_idx] <= 1'b1;
        next_id_q         <= (next_id_q == ID_LAST) ? ID_FIRST : next_id_q + ID_W'(1);
      end
      if (cmd_i.do_cancel && hit_found) begin
        valid_q[hit_idx] <= 1'b0;
      end
      if (cmd_i.snap) begin
        pend_q       <= expired;
        idx_q        <= '0;
        best_found_q <= 1'b0;
        cnt_q        <= '0;
      end
      if (cmd_i.scan_step) begin
        if (cand) best_found_q <= 1'b1;
        idx_q <= (idx_q == IDX_W'(CAPACITY - 1)) ? '0 : idx_q + IDX_W'(1);
      end
      if (cmd_i.emit) begin
        valid_q[best_idx_q] <= 1'b0;
        pend_q              <= pend_left;
        best_found_q        <= 1'b0;
        idx_q               <= '0;
        cnt_q               <= cnt_q + CNT_W'(1);
      end
      if (out_wr) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q   <= mode_i;
      delay_q  <= delay_ticks_i;
      target_q <= target_id_i;
    end
    if (cmd_i.do_post && free_found) begin
      id_q[free_idx] <= next_id_q;
      dl_q[free_idx] <= now_q + TICK_W'(delay_q);
    end
    if (cmd_i.scan_step && cand) begin
      best_idx_q <= idx_q;
      best_id_q  <= id_q[idx_q];
    end
    if (cmd_i.do_post) begin
      kind_q     <= KIND_POST;
      timer_id_q <= free_found ? next_id_q : '0;
      failed_q   <= !free_found;
      last_q     <= 1'b1;
    end else if (cmd_i.do_cancel) begin
      kind_q     <= KIND_CANCEL;
      timer_id_q <= target_q;
      failed_q   <= !hit_found;
      last_q     <= 1'b1;
    end else if (cmd_i.emit) begin
      kind_q     <= KIND_EXPIRED;
      timer_id_q <= best_id_q;
      failed_q   <= 1'b0;
      last_q     <= sts_o.emit_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign kind_o      = kind_q;
  assign timer_id_o  = timer_id_q;
  assign failed_o    = failed_q;
  assign last_o      = last_q;

endmodule

// ===== rtl/ctq_checker.sv =====
// ctq_checker: port-level assertions for the timer queue, bound to the top.
// Depends on ctq_pkg and cancellable_timer_queue_top.
module ctq_checker import ctq_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_i,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input logic [KIND_W-1:0] kind_i,
  input logic [ID_W-1:0]   timer_id_i,
  input logic              failed_i,
  input logic              last_i
);

  // one word in flight: ready drops right after an accept
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> !in_ready_i)
    else $error("input accepted while previous word still in work");

  // only an expiry burst yields results that are not the last
  a_burst_only_expired: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !last_i) |-> (kind_i == KIND_EXPIRED))
    else $error("non-final result outside an expiry burst");

  // post replies: failure carries id zero, success a nonzero id
  a_post_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && (kind_i == KIND_POST)) |-> (failed_i == (timer_id_i == '0)))
    else $error("post reply id inconsistent with failed flag");

  // held result stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> (out_valid_i && $stable(timer_id_i)
      && $stable(kind_i) && $stable(last_i)))
    else $error("stalled result changed");

endmodule

bind cancellable_timer_queue_top ctq_checker u_ctq_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .kind_i      (out_o.kind),
  .timer_id_i  (out_o.timer_id),
  .failed_i    (out_o.failed),
  .last_i      (out_o.last)
);
